@@ hw/rtl/vic_pkg.sv @@
`timescale 1ns / 1ps

package vic_pkg;

   // Index selector codes; the unused code computes NDVI.
   localparam logic [1:0] KIND_NDVI = 2'd0;
   localparam logic [1:0] KIND_EVI  = 2'd1;
   localparam logic [1:0] KIND_SAVI = 2'd2;

   // Health bands, worst to best.
   localparam logic [2:0] BAND_BARE     = 3'd0;
   localparam logic [2:0] BAND_SPARSE   = 3'd1;
   localparam logic [2:0] BAND_MODERATE = 3'd2;
   localparam logic [2:0] BAND_DENSE    = 3'd3;
   localparam logic [2:0] BAND_LUSH     = 3'd4;

   localparam logic [7:0] COLOR_OFF  = 8'd0;
   localparam logic [7:0] COLOR_HALF = 8'd128;
   localparam logic [7:0] COLOR_FULL = 8'd255;

   localparam int REQ_DATA_WIDTH = 24;
   localparam int RSP_DATA_WIDTH = 32;

   typedef struct packed {
      logic [7:0] blue_level;
      logic [7:0] red_level;
      logic [7:0] nir_level;
   } pixel_type;

   // Index as an exact fraction num / den.
   typedef struct packed {
      logic signed [12:0] num;
      logic signed [12:0] den;
   } ratio_type;

   // Fraction with an unsigned denominator and the numerator already times four.
   typedef struct packed {
      logic signed [14:0] num4;
      logic [11:0]        den;
      logic               zero_den;
      logic               neg_num;
   } norm_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [2:0] health_class;
   } result_type;

   function automatic logic [7:0] band_green(input logic [2:0] band);
      logic [7:0] color;
      case (band)
         BAND_BARE:     color = COLOR_OFF;
         BAND_SPARSE:   color = COLOR_HALF;
         BAND_MODERATE: color = COLOR_FULL;
         BAND_DENSE:    color = COLOR_FULL;
         BAND_LUSH:     color = COLOR_HALF;
         default:       color = COLOR_OFF;
      endcase
      return color;
   endfunction

   function automatic logic [7:0] band_red(input logic [2:0] band);
      logic [7:0] color;
      case (band)
         BAND_BARE:     color = COLOR_FULL;
         BAND_SPARSE:   color = COLOR_FULL;
         BAND_MODERATE: color = COLOR_FULL;
         BAND_DENSE:    color = COLOR_OFF;
         BAND_LUSH:     color = COLOR_OFF;
         default:       color = COLOR_OFF;
      endcase
      return color;
   endfunction

endpackage

@@ hw/rtl/vic_ratio.sv @@
`timescale 1ns / 1ps

module vic_ratio
   import vic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] index_kind,
   input  logic       in_valid,
   output logic       in_ready,
   input  pixel_type  in_pixel,
   output logic       out_valid,
   input  logic       out_ready,
   output ratio_type  out_ratio
);

   logic               valid_ff;
   logic               valid_in;
   ratio_type          ratio_ff;
   ratio_type          ratio_in;
   logic signed [12:0] nir;
   logic signed [12:0] red;
   logic signed [12:0] blue;
   logic signed [12:0] diff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      nir  = $signed({5'b0, in_pixel.nir_level});
      red  = $signed({5'b0, in_pixel.red_level});
      blue = $signed({5'b0, in_pixel.blue_level});
      diff = nir - red;
      case (index_kind)
         KIND_EVI: begin
            // EVI is scaled by two so that every coefficient is an integer.
            ratio_in.num = 13'sd9 * diff;
            ratio_in.den = 13'sd2 * nir + 13'sd12 * red - 13'sd9 * blue + 13'sd2;
         end
         KIND_SAVI: begin
            ratio_in.num = 13'sd3 * diff;
            ratio_in.den = nir + red + 13'sd2;
         end
         default: begin
            ratio_in.num = diff;
            ratio_in.den = nir + red;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         ratio_ff <= ratio_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ratio = ratio_ff;

endmodule

@@ hw/rtl/vic_norm.sv @@
`timescale 1ns / 1ps

module vic_norm
   import vic_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  ratio_type in_ratio,
   output logic      out_valid,
   input  logic      out_ready,
   output norm_type  out_norm
);

   logic               valid_ff;
   logic               valid_in;
   norm_type           norm_ff;
   norm_type           norm_in;
   logic               flip;
   logic signed [12:0] num_abs;
   logic signed [12:0] den_abs;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      // A negative denominator flips the signs of both terms.
      flip             = in_ratio.den < 13'sd0;
      num_abs          = flip ? -in_ratio.num : in_ratio.num;
      den_abs          = flip ? -in_ratio.den : in_ratio.den;
      norm_in.num4     = $signed({num_abs, 2'b00});
      norm_in.den      = den_abs[11:0];
      norm_in.zero_den = in_ratio.den == 13'sd0;
      norm_in.neg_num  = in_ratio.num < 13'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         norm_ff <= norm_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_norm  = norm_ff;

endmodule

@@ hw/rtl/vic_band.sv @@
`timescale 1ns / 1ps

module vic_band
   import vic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  norm_type   in_norm,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic               valid_ff;
   logic               valid_in;
   result_type         result_ff;
   result_type         result_in;
   logic signed [14:0] den1;
   logic signed [14:0] den2;
   logic signed [14:0] den3;
   logic [2:0]         band;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      den1 = $signed({3'b000, in_norm.den});
      den2 = $signed({2'b00, in_norm.den, 1'b0});
      den3 = den1 + den2;
      // Each bound is inclusive from above: index <= k/4 is 4*num <= k*den.
      if (in_norm.zero_den) begin
         band = in_norm.neg_num ? BAND_BARE : BAND_LUSH;
      end else if (in_norm.num4 <= 15'sd0) begin
         band = BAND_BARE;
      end else if (in_norm.num4 <= den1) begin
         band = BAND_SPARSE;
      end else if (in_norm.num4 <= den2) begin
         band = BAND_MODERATE;
      end else if (in_norm.num4 <= den3) begin
         band = BAND_DENSE;
      end else begin
         band = BAND_LUSH;
      end
      result_in.health_class = band;
      result_in.out_blue     = COLOR_OFF;
      result_in.out_green    = band_green(band);
      result_in.out_red      = band_red(band);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

@@ hw/rtl/vegetation_index_classifier.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_tvalid/tready    nir_level, red_level, blue_level
// rsp       out        rsp_tvalid/tready    health_class, out_blue, out_green, out_red
// csr       in         csr_valid/csr_ready  index_kind
//
// One word per cycle in and out while rsp is not stalled; each pixel passes through
// the registered ratio, sign and band stages in that order before its result appears.
// Each stage takes a new word whenever it is empty or its successor takes its word,
// so bubbles close up and a stall on rsp holds every word in place.
// Reset empties the stages and sets index_kind to NDVI; csr is always ready.

module vegetation_index_classifier
   import vic_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // nir_level [7:0], red_level [15:8], blue_level [23:16]
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // health_class [2:0], out_blue [10:3], out_green [18:11], out_red [26:19], zero above
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_data
);

   logic [1:0] index_kind_ff;
   logic [1:0] index_kind_in;
   logic       ratio_valid;
   logic       ratio_ready;
   ratio_type  ratio;
   logic       norm_valid;
   logic       norm_ready;
   norm_type   norm;
   result_type result;

   assign csr_ready     = 1'b1;
   assign index_kind_in = (csr_valid && csr_ready) ? csr_data : index_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_kind_ff <= KIND_NDVI;
      end else begin
         index_kind_ff <= index_kind_in;
      end
   end

   vic_ratio u_ratio (
      .clock      (clock),
      .reset      (reset),
      .index_kind (index_kind_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_pixel   (pixel_type'(req_tdata)),
      .out_valid  (ratio_valid),
      .out_ready  (ratio_ready),
      .out_ratio  (ratio)
   );

   vic_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ratio_valid),
      .in_ready  (ratio_ready),
      .in_ratio  (ratio),
      .out_valid (norm_valid),
      .out_ready (norm_ready),
      .out_norm  (norm)
   );

   vic_band u_band (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (norm_valid),
      .in_ready   (norm_ready),
      .in_norm    (norm),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {5'b00000, result};

endmodule

@@ hw/rtl/vic_checker.sv @@
`timescale 1ns / 1ps

module vic_checker
   import vic_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   // An accepted pixel, with the output idle and the sink ready, reaches the output.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid && rsp_tready)
         ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("pixel did not reach the output in three cycles");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // The colour must match the class.
   a_colour: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:3] == 8'd0 && rsp_tdata[31:27] == 5'd0 &&
         ((rsp_tdata[2:0] == BAND_BARE     && rsp_tdata[26:11] == 16'hFF00) ||
          (rsp_tdata[2:0] == BAND_SPARSE   && rsp_tdata[26:11] == 16'hFF80) ||
          (rsp_tdata[2:0] == BAND_MODERATE && rsp_tdata[26:11] == 16'hFFFF) ||
          (rsp_tdata[2:0] == BAND_DENSE    && rsp_tdata[26:11] == 16'h00FF) ||
          (rsp_tdata[2:0] == BAND_LUSH     && rsp_tdata[26:11] == 16'h0080)))
      else $error("result class and colour disagree");

   // With an always-ready sink, no word is dropped.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tready && $past(rsp_tready) && $past(rsp_tready, 2) && $past(rsp_tready, 3) &&
         $past(req_tvalid && req_tready, 3) && !$past(reset, 3) && !$past(reset, 2) &&
         !$past(reset) |-> rsp_tvalid)
      else $error("accepted pixel produced no result word");

endmodule

bind vegetation_index_classifier vic_checker u_vic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import vic_pkg::*;

   // The package names three selector codes; the fourth falls back to NDVI.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 150;

   class health_scoreboard;
      result_type expected_health[$];
      logic [1:0] index_kind;
      int errors;

      function new();
         index_kind = KIND_NDVI;
         errors = 0;
      endfunction

      function void set_kind(logic [1:0] kind);
         index_kind = kind;
      endfunction

      function int pending();
         return expected_health.size();
      endfunction

      // Exact fraction test: index <= k/4 becomes 4*num <= k*den once den > 0.
      function result_type classify_pixel(pixel_type px);
         int n, r, b, num, den;
         logic [2:0] band;
         result_type res;
         n = px.nir_level;
         r = px.red_level;
         b = px.blue_level;
         case (index_kind)
            KIND_EVI: begin
               num = 9 * (n - r);
               den = 2 * n + 12 * r - 9 * b + 2;
            end
            KIND_SAVI: begin
               num = 3 * (n - r);
               den = n + r + 2;
            end
            default: begin
               num = n - r;
               den = n + r;
            end
         endcase
         if (den == 0) begin
            band = (num < 0) ? BAND_BARE : BAND_LUSH;
         end else begin
            if (den < 0) begin
               num = -num;
               den = -den;
            end
            if (num <= 0) band = BAND_BARE;
            else if (4 * num <= den) band = BAND_SPARSE;
            else if (4 * num <= 2 * den) band = BAND_MODERATE;
            else if (4 * num <= 3 * den) band = BAND_DENSE;
            else band = BAND_LUSH;
         end
         res.health_class = band;
         res.out_blue = COLOR_OFF;
         case (band)
            BAND_BARE: begin
               res.out_green = COLOR_OFF;
               res.out_red = COLOR_FULL;
            end
            BAND_SPARSE: begin
               res.out_green = COLOR_HALF;
               res.out_red = COLOR_FULL;
            end
            BAND_MODERATE: begin
               res.out_green = COLOR_FULL;
               res.out_red = COLOR_FULL;
            end
            BAND_DENSE: begin
               res.out_green = COLOR_FULL;
               res.out_red = COLOR_OFF;
            end
            default: begin
               res.out_green = COLOR_HALF;
               res.out_red = COLOR_OFF;
            end
         endcase
         return res;
      endfunction

      function void note_pixel(pixel_type px);
         expected_health = {expected_health, classify_pixel(px)};
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(logic [RSP_DATA_WIDTH-1:0] word);
         result_type want, got;
         if (expected_health.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, actual 0x%h", $time, word);
            return;
         end
         want = expected_health.pop_front();
         got = word[$bits(result_type)-1:0];
         compare_field("health_class", want.health_class, got.health_class);
         compare_field("out_blue", want.out_blue, got.out_blue);
         compare_field("out_green", want.out_green, got.out_green);
         compare_field("out_red", want.out_red, got.out_red);
         compare_field("padding", 0, word[RSP_DATA_WIDTH-1:$bits(result_type)]);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_data;
   logic steady;
   int cycle_count;

   health_scoreboard board = new();

   vegetation_index_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // The receiver stalls at random except during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 26);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.set_kind(csr_data);
         if (req_tvalid && req_tready) board.note_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      end
   end

   function automatic pixel_type make_pixel(int n, int r, int b);
      pixel_type px;
      px.nir_level = n[7:0];
      px.red_level = r[7:0];
      px.blue_level = b[7:0];
      return px;
   endfunction

   function automatic int clamp_byte(int v);
      return (v < 0) ? 0 : ((v > 255) ? 255 : v);
   endfunction

   function automatic int edge_byte();
      case ($urandom_range(3))
         0: return 0;
         1: return 1;
         2: return 254;
         default: return 255;
      endcase
   endfunction

   // Mixes uniform pixels with small ones, field extremes and ones that land near
   // the band thresholds and near a vanishing EVI denominator.
   function automatic pixel_type random_pixel();
      int n, r, b;
      n = $urandom_range(255);
      r = $urandom_range(255);
      b = $urandom_range(255);
      case ($urandom_range(4))
         1: begin
            n = $urandom_range(15);
            r = $urandom_range(15);
            b = $urandom_range(15);
         end
         2: begin
            r = $urandom_range(1, 36);
            case ($urandom_range(2))
               0: n = (5 * r) / 3;
               1: n = 3 * r;
               default: n = 7 * r;
            endcase
            n = clamp_byte(n + $urandom_range(2) - 1);
         end
         3: begin
            n = $urandom_range(100);
            r = $urandom_range(15);
            b = clamp_byte((2 * n + 12 * r + 2) / 9 + $urandom_range(2) - 1);
         end
         4: begin
            n = edge_byte();
            r = edge_byte();
            b = edge_byte();
         end
         default: ;
      endcase
      return make_pixel(n, r, b);
   endfunction

   task automatic send_pixel(pixel_type px);
      while (!steady && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Waits until every pixel sent so far has its result back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_kind(logic [1:0] kind);
      drain();
      csr_valid <= 1'b1;
      csr_data <= kind;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [1:0] phase_kind [RANDOM_PHASES];
      phase_kind = '{KIND_EVI, KIND_SAVI, KIND_NDVI, KIND_UNUSED,
                     KIND_EVI, KIND_SAVI, KIND_NDVI, KIND_EVI};
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_data <= KIND_NDVI;
      steady <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // NDVI: field extremes, zero numerator, zero denominator, exact thresholds.
      write_kind(KIND_NDVI);
      send_pixel(make_pixel(0, 0, 0));
      send_pixel(make_pixel(255, 255, 255));
      send_pixel(make_pixel(255, 0, 0));
      send_pixel(make_pixel(0, 255, 0));
      send_pixel(make_pixel(0, 0, 255));
      send_pixel(make_pixel(5, 3, 0));
      send_pixel(make_pixel(3, 1, 0));
      send_pixel(make_pixel(7, 1, 0));
      send_pixel(make_pixel(8, 1, 170));

      // EVI: zero denominator with both signs of numerator, negative denominator.
      write_kind(KIND_EVI);
      send_pixel(make_pixel(8, 0, 2));
      send_pixel(make_pixel(2, 4, 6));
      send_pixel(make_pixel(0, 0, 255));
      send_pixel(make_pixel(255, 0, 255));
      send_pixel(make_pixel(255, 0, 0));

      write_kind(KIND_SAVI);
      send_pixel(make_pixel(255, 0, 0));
      send_pixel(make_pixel(0, 0, 0));
      send_pixel(make_pixel(7, 1, 85));

      write_kind(KIND_UNUSED);
      send_pixel(make_pixel(0, 0, 0));
      send_pixel(make_pixel(3, 1, 255));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_kind(phase_kind[phase]);
         steady <= (phase == 3);
         for (int i = 0; i < PHASE_ITEMS; i++) send_pixel(random_pixel());
      end
      steady <= 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (board.errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/vic_pkg.sv
hw/rtl/vic_ratio.sv
hw/rtl/vic_norm.sv
hw/rtl/vic_band.sv
hw/rtl/vegetation_index_classifier.sv
hw/rtl/vic_checker.sv
sim/testbench.sv
